// ----- src/cds_pkg.sv -----
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, widths and calendar constants for the date stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int YEAR_W      = 16;
  localparam int MONTH_W     = 4;
  localparam int DAY_W       = 5;
  localparam int COUNT_WIDTH = 12;

  localparam logic [YEAR_W-1:0]  RESET_YEAR  = YEAR_W'(2001);
  localparam logic [MONTH_W-1:0] RESET_MONTH = MONTH_W'(1);
  localparam logic [DAY_W-1:0]   RESET_DAY   = DAY_W'(1);

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_MAR = MONTH_W'(3);
  localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  localparam logic [DAY_W-1:0] DAY_FIRST = DAY_W'(1);
  localparam logic [DAY_W-1:0] DAYS_28   = DAY_W'(28);
  localparam logic [DAY_W-1:0] DAYS_29   = DAY_W'(29);
  localparam logic [DAY_W-1:0] DAYS_30   = DAY_W'(30);
  localparam logic [DAY_W-1:0] DAYS_31   = DAY_W'(31);

  // Divisibility by 25: y is a multiple of 25 exactly when y times the
  // inverse of 25 modulo 2^16 lands at or below floor((2^16 - 1) / 25).
  localparam logic [YEAR_W-1:0] INV25     = YEAR_W'(23593);
  localparam logic [YEAR_W-1:0] DIV25_MAX = YEAR_W'(((1 << YEAR_W) - 1) / 25);

  typedef enum logic [1:0] {
    FUNC_LOAD       = 2'd0,
    FUNC_ADD_DAYS   = 2'd1,
    FUNC_ADD_MONTHS = 2'd2,
    FUNC_ADD_YEARS  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DAYS,
    ST_MONTHS,
    ST_CLAMP,
    ST_YEARS,
    ST_YEAR_FIX,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             leap;
    logic [DAY_W-1:0] len;
  } mlen_t;

endpackage

// ----- src/cds_month_len.sv -----
// ----------------------------------------------------------------------------
// cds_month_len
// Shared month-length unit: leap rule and day count for one year and month.
// ----------------------------------------------------------------------------
module cds_month_len (
  input  logic [cds_pkg::YEAR_W-1:0]  year_i,
  input  logic [cds_pkg::MONTH_W-1:0] month_i,
  output cds_pkg::mlen_t              mlen_o
);

  logic [2*cds_pkg::YEAR_W-1:0] prod_full;
  logic                         div25;
  logic                         leap;

  assign prod_full = (2*cds_pkg::YEAR_W)'(year_i) * (2*cds_pkg::YEAR_W)'(cds_pkg::INV25);
  assign div25     = (prod_full[cds_pkg::YEAR_W-1:0] <= cds_pkg::DIV25_MAX);

  // 4/100/400 rule: a multiple of 100 must also be a multiple of 16
  assign leap = (year_i[1:0] == 2'b00) && (!div25 || (year_i[3:0] == 4'b0000));

  always_comb begin
    mlen_o.leap = leap;
    if (month_i == cds_pkg::MONTH_FEB) begin
      mlen_o.len = leap ? cds_pkg::DAYS_29 : cds_pkg::DAYS_28;
    end else if (month_i == cds_pkg::MONTH_APR || month_i == cds_pkg::MONTH_JUN ||
                 month_i == cds_pkg::MONTH_SEP || month_i == cds_pkg::MONTH_NOV) begin
      mlen_o.len = cds_pkg::DAYS_30;
    end else begin
      mlen_o.len = cds_pkg::DAYS_31;
    end
  end

endmodule

// ----- src/calendar_date_stepper_core.sv -----
// ----------------------------------------------------------------------------
// calendar_date_stepper_core
// Gregorian date register stepped by load, add-days, add-months, add-years.
// ----------------------------------------------------------------------------
// Load: check, then done. Add-years: year add, Feb 29 fix, done. Add-days:
// count day steps, then done. Add-months: count month steps, day clamp, done.
// One request at a time; the next is taken once the sequencer is back in
// idle, i.e. in the cycle the result appears. The day and month loops step
// once per cycle; the day loop and the clamp use the shared month-length unit.
// Asynchronous active-low reset sets the date to 2001-01-01, empties output.
module calendar_date_stepper_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      func_i,
  input  logic [cds_pkg::YEAR_W-1:0]      load_year_i,
  input  logic [cds_pkg::MONTH_W-1:0]     load_month_i,
  input  logic [cds_pkg::DAY_W-1:0]       load_day_i,
  input  logic [cds_pkg::COUNT_WIDTH-1:0] count_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [cds_pkg::YEAR_W-1:0]      cur_year_o,
  output logic [cds_pkg::MONTH_W-1:0]     cur_month_o,
  output logic [cds_pkg::DAY_W-1:0]       cur_day_o,
  output logic                            bad_date_o
);

  cds_pkg::state_e state_q, state_d;

  // current date, the architectural state
  logic [cds_pkg::YEAR_W-1:0]      year_q, year_d;
  logic [cds_pkg::MONTH_W-1:0]     month_q, month_d;
  logic [cds_pkg::DAY_W-1:0]       day_q, day_d;
  logic                            bad_q, bad_d;

  // latched request operands
  logic [cds_pkg::YEAR_W-1:0]      op_year_q, op_year_d;
  logic [cds_pkg::MONTH_W-1:0]     op_month_q, op_month_d;
  logic [cds_pkg::DAY_W-1:0]       op_day_q, op_day_d;
  logic [cds_pkg::COUNT_WIDTH-1:0] cnt_q, cnt_d;

  // output register, parts the sequencer from the result consumer
  logic                            out_valid_q, out_valid_d;
  logic [cds_pkg::YEAR_W-1:0]      out_year_q, out_year_d;
  logic [cds_pkg::MONTH_W-1:0]     out_month_q, out_month_d;
  logic [cds_pkg::DAY_W-1:0]       out_day_q, out_day_d;
  logic                            out_bad_q, out_bad_d;

  // shared month-length unit operands
  logic [cds_pkg::YEAR_W-1:0]      unit_year;
  logic [cds_pkg::MONTH_W-1:0]     unit_month;
  cds_pkg::mlen_t                  mlen;
  logic                            load_bad;

  // Feed the unit with the request operands while checking a load, and with
  // the stored date for every stepping and clamping cycle.
  assign unit_year  = (state_q == cds_pkg::ST_LOAD) ? op_year_q  : year_q;
  assign unit_month = (state_q == cds_pkg::ST_LOAD) ? op_month_q : month_q;

  cds_month_len u_month_len (
    .year_i  (unit_year),
    .month_i (unit_month),
    .mlen_o  (mlen)
  );

  // A month outside 1..12 makes the unit's length meaningless, but the
  // month range test rejects such a load on its own.
  assign load_bad = (op_day_q == '0) || (op_month_q < cds_pkg::MONTH_JAN) ||
                    (op_month_q > cds_pkg::MONTH_DEC) || (op_day_q > mlen.len);

  assign in_stall_o  = (state_q != cds_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cur_year_o  = out_year_q;
  assign cur_month_o = out_month_q;
  assign cur_day_o   = out_day_q;
  assign bad_date_o  = out_bad_q;

  always_comb begin
    state_d     = state_q;
    year_d      = year_q;
    month_d     = month_q;
    day_d       = day_q;
    bad_d       = bad_q;
    op_year_d   = op_year_q;
    op_month_d  = op_month_q;
    op_day_d    = op_day_q;
    cnt_d       = cnt_q;
    out_year_d  = out_year_q;
    out_month_d = out_month_q;
    out_day_d   = out_day_q;
    out_bad_d   = out_bad_q;
    // drop the result once the consumer takes it
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      cds_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_year_d  = load_year_i;
          op_month_d = load_month_i;
          op_day_d   = load_day_i;
          cnt_d      = count_i;
          bad_d      = 1'b0;
          case (cds_pkg::func_e'(func_i))
            cds_pkg::FUNC_LOAD:       state_d = cds_pkg::ST_LOAD;
            cds_pkg::FUNC_ADD_DAYS:   state_d = cds_pkg::ST_DAYS;
            cds_pkg::FUNC_ADD_MONTHS: state_d = cds_pkg::ST_MONTHS;
            cds_pkg::FUNC_ADD_YEARS:  state_d = cds_pkg::ST_YEARS;
            default:                  state_d = cds_pkg::ST_LOAD;
          endcase
        end
      end

      cds_pkg::ST_LOAD: begin
        // take the new date only if it passes the check
        if (load_bad) begin
          bad_d = 1'b1;
        end else begin
          year_d  = op_year_q;
          month_d = op_month_q;
          day_d   = op_day_q;
        end
        state_d = cds_pkg::ST_DONE;
      end

      cds_pkg::ST_DAYS: begin
        // advance one day per cycle, rolling month and year over
        if (cnt_q == '0) begin
          state_d = cds_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q - cds_pkg::COUNT_WIDTH'(1);
          if (day_q >= mlen.len) begin
            day_d = cds_pkg::DAY_FIRST;
            if (month_q >= cds_pkg::MONTH_DEC) begin
              month_d = cds_pkg::MONTH_JAN;
              year_d  = year_q + cds_pkg::YEAR_W'(1);
            end else begin
              month_d = month_q + cds_pkg::MONTH_W'(1);
            end
          end else begin
            day_d = day_q + cds_pkg::DAY_W'(1);
          end
        end
      end

      cds_pkg::ST_MONTHS: begin
        // advance one month per cycle; the day is fixed up afterwards
        if (cnt_q == '0) begin
          state_d = cds_pkg::ST_CLAMP;
        end else begin
          cnt_d = cnt_q - cds_pkg::COUNT_WIDTH'(1);
          if (month_q >= cds_pkg::MONTH_DEC) begin
            month_d = cds_pkg::MONTH_JAN;
            year_d  = year_q + cds_pkg::YEAR_W'(1);
          end else begin
            month_d = month_q + cds_pkg::MONTH_W'(1);
          end
        end
      end

      cds_pkg::ST_CLAMP: begin
        // clamp the day to the length of the month reached
        if (day_q > mlen.len) begin
          day_d = mlen.len;
        end
        state_d = cds_pkg::ST_DONE;
      end

      cds_pkg::ST_YEARS: begin
        year_d  = year_q + cds_pkg::YEAR_W'(cnt_q);
        state_d = cds_pkg::ST_YEAR_FIX;
      end

      cds_pkg::ST_YEAR_FIX: begin
        // Feb 29 of a target year that is not leap becomes Mar 1
        if (month_q == cds_pkg::MONTH_FEB && day_q == cds_pkg::DAYS_29 && !mlen.leap) begin
          month_d = cds_pkg::MONTH_MAR;
          day_d   = cds_pkg::DAY_FIRST;
        end
        state_d = cds_pkg::ST_DONE;
      end

      cds_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_year_d  = year_q;
          out_month_d = month_q;
          out_day_d   = day_q;
          out_bad_d   = bad_q;
          state_d     = cds_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = cds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cds_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q      <= cds_pkg::RESET_YEAR;
      month_q     <= cds_pkg::RESET_MONTH;
      day_q       <= cds_pkg::RESET_DAY;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      year_q      <= year_d;
      month_q     <= month_d;
      day_q       <= day_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_year_q   <= op_year_d;
    op_month_q  <= op_month_d;
    op_day_q    <= op_day_d;
    cnt_q       <= cnt_d;
    out_year_q  <= out_year_d;
    out_month_q <= out_month_d;
    out_day_q   <= out_day_d;
    out_bad_q   <= out_bad_d;
  end

  // The stored month always stays in 1..12 and the stored day is never zero.
  a_month_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (month_q >= cds_pkg::MONTH_JAN) && (month_q <= cds_pkg::MONTH_DEC))
    else $error("stored month out of range");

  a_day_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    day_q != '0)
    else $error("stored day is zero");

  // A rejected load leaves the date untouched.
  a_bad_load_keeps_date : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cds_pkg::ST_LOAD) && load_bad |=>
      $stable(year_q) && $stable(month_q) && $stable(day_q) && bad_q)
    else $error("rejected load changed the date");

  // Each day step consumes exactly one from the count.
  a_day_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cds_pkg::ST_DAYS) && (cnt_q != '0) |=>
      cnt_q == $past(cnt_q) - cds_pkg::COUNT_WIDTH'(1))
    else $error("day count did not step by one");

endmodule
